[design/xtea_pkg.sv]
// Shared types, constants and helpers for the XTEA block cipher.
`default_nettype none

package xtea_pkg;

  localparam int WORD_W      = 32;
  localparam int CYCLE_COUNT = 32;
  localparam int NUM_STAGES  = 2 * CYCLE_COUNT;
  localparam int KEY_WORDS   = 4;
  localparam int CFG_INDEX_W = 4;

  localparam logic [WORD_W-1:0] XTEA_DELTA = 32'h9E37_79B9;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_set_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_KEY0 = 4'd0,
    REG_KEY1 = 4'd1,
    REG_KEY2 = 4'd2,
    REG_KEY3 = 4'd3
  } reg_index_t;

  typedef struct packed {
    logic  func;
    word_t v0;
    word_t v1;
  } blk_t;

  function automatic word_t mix_word(input word_t w);
    return ((w << 4) ^ (w >> 5)) + w;
  endfunction

  // Running sum seen by half-round h (elaboration time only).
  function automatic word_t half_sum(input logic dec, input int h);
    int          c;
    int          m;
    logic [63:0] p;
    c = h >> 1;
    m = dec ? (CYCLE_COUNT - c - (h & 1)) : (c + (h & 1));
    p = 64'(m) * 64'(XTEA_DELTA);
    return p[WORD_W-1:0];
  endfunction

endpackage

`default_nettype wire

[design/xtea_ifs.sv]
// Channel interfaces: block input, block output and register write.
`default_nettype none

interface xtea_blk_in_if import xtea_pkg::*;;
  logic  valid;
  logic  ready;
  logic  func;
  word_t in_first;
  word_t in_second;
  modport source (output valid, func, in_first, in_second, input ready);
  modport sink (input valid, func, in_first, in_second, output ready);
endinterface

interface xtea_blk_out_if import xtea_pkg::*;;
  logic  valid;
  logic  ready;
  word_t out_first;
  word_t out_second;
  modport source (output valid, out_first, out_second, input ready);
  modport sink (input valid, out_first, out_second, output ready);
endinterface

interface xtea_cfg_if import xtea_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  word_t                  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[design/xtea_round.sv]
// One registered Feistel half-round of the XTEA pipeline.
`default_nettype none

module xtea_round import xtea_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     en,
  input  wire logic     odd,
  input  wire word_t    sum_enc,
  input  wire word_t    sum_dec,
  input  wire key_set_t key,
  input  wire logic     vld_prev,
  input  wire blk_t     blk_prev,
  output logic          vld,
  output blk_t          blk
);

  logic             dec;
  logic             upd_first;
  word_t            sum;
  logic [1:0]       kidx;
  word_t            src;
  word_t            tgt;
  word_t            f;
  word_t            res;
  blk_t             blk_next;

  always_comb begin
    dec       = blk_prev.func;
    upd_first = ~(dec ^ odd);
    sum       = dec ? sum_dec : sum_enc;
    kidx      = upd_first ? sum[1:0] : sum[12:11];
    src       = upd_first ? blk_prev.v1 : blk_prev.v0;
    tgt       = upd_first ? blk_prev.v0 : blk_prev.v1;
    f         = mix_word(src) ^ (sum + key[kidx]);
    res       = dec ? (tgt - f) : (tgt + f);
    blk_next  = blk_prev;
    if (upd_first) begin
      blk_next.v0 = res;
    end else begin
      blk_next.v1 = res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= vld_prev;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      blk <= blk_next;
    end
  end

endmodule

`default_nettype wire

[design/xtea_pipe.sv]
// Fully unrolled XTEA pipeline, one half-round per stage.
`default_nettype none

module xtea_pipe import xtea_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     en,
  input  wire key_set_t key,
  input  wire logic     vld_in,
  input  wire blk_t     blk_in,
  output logic          vld_out,
  output blk_t          blk_out
);

  logic vld [NUM_STAGES+1];
  blk_t blk [NUM_STAGES+1];

  assign vld[0] = vld_in;
  assign blk[0] = blk_in;

  for (genvar h = 0; h < NUM_STAGES; h++) begin : g_stage
    xtea_round u_round (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .odd      (1'(h % 2)),
      .sum_enc  (half_sum(1'b0, h)),
      .sum_dec  (half_sum(1'b1, h)),
      .key      (key),
      .vld_prev (vld[h]),
      .blk_prev (blk[h]),
      .vld      (vld[h+1]),
      .blk      (blk[h+1])
    );
  end

  assign vld_out = vld[NUM_STAGES];
  assign blk_out = blk[NUM_STAGES];

endmodule

`default_nettype wire

[design/xtea_oskid.sv]
// Output register with skid entry; parts the pipeline from the sink.
`default_nettype none

module xtea_oskid import xtea_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic up_valid,
  input  wire blk_t up_data,
  output logic      up_ready,
  output logic      dn_valid,
  output blk_t      dn_data,
  input  wire logic dn_ready
);

  logic main_valid;
  blk_t main_data;
  logic skid_valid;
  blk_t skid_data;
  logic move;

  assign move     = dn_ready || !main_valid;
  assign up_ready = !skid_valid;
  assign dn_valid = main_valid;
  assign dn_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (move) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= up_valid;
      end
    end else if (up_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      main_data <= skid_valid ? skid_data : up_data;
    end else if (up_valid && !skid_valid) begin
      skid_data <= up_data;
    end
  end

  a_skid_needs_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid entry held without output beat");

  a_skid_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(main_valid && !dn_ready && up_valid))
    else $error("skid filled without a stalled output");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && dn_ready) |=> (!skid_valid && main_valid &&
      main_data == $past(skid_data)))
    else $error("skid entry not moved to output");

endmodule

`default_nettype wire

[design/xtea_block_cipher.sv]
// Top level of the pipelined XTEA block cipher.
//
//  channel | dir | beat                         | accept
//  blk_in  | in  | func, in_first, in_second    | valid && ready
//  blk_out | out | out_first, out_second        | valid && ready
//  cfg     | in  | index, data (key words 0..3) | valid && ready (ready always 1)
//
//  One block per cycle while the output is not stalled; each block passes the
//  64 half-round stages and then the output register on its way to the output.
//  Synchronous reset clears all valid bits and the key words to zero.
//  A stalled output fills the skid entry, which freezes the whole pipeline
//  and drops blk_in.ready until the output is taken; nothing is lost.
`default_nettype none

module xtea_block_cipher import xtea_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  xtea_blk_in_if.sink   blk_in,
  xtea_blk_out_if.source blk_out,
  xtea_cfg_if.sink      cfg
);

  key_set_t key;
  logic     en;
  blk_t     blk_first;
  logic     pipe_valid;
  blk_t     pipe_data;
  blk_t     out_data;
  logic     cfg_wr;

  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid && cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_wr) begin
      unique case (reg_index_t'(cfg.index))
        REG_KEY0: key[0] <= cfg.data;
        REG_KEY1: key[1] <= cfg.data;
        REG_KEY2: key[2] <= cfg.data;
        REG_KEY3: key[3] <= cfg.data;
        default: ;
      endcase
    end
  end

  assign blk_in.ready = en;
  assign blk_first    = '{func: blk_in.func, v0: blk_in.in_first, v1: blk_in.in_second};

  xtea_pipe u_pipe (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .key     (key),
    .vld_in  (blk_in.valid),
    .blk_in  (blk_first),
    .vld_out (pipe_valid),
    .blk_out (pipe_data)
  );

  xtea_oskid u_oskid (
    .clk      (clk),
    .rst      (rst),
    .up_valid (pipe_valid),
    .up_data  (pipe_data),
    .up_ready (en),
    .dn_valid (blk_out.valid),
    .dn_data  (out_data),
    .dn_ready (blk_out.ready)
  );

  assign blk_out.out_first  = out_data.v0;
  assign blk_out.out_second = out_data.v1;

  a_key0_write: assert property (@(posedge clk) disable iff (rst)
    (cfg_wr && cfg.index == REG_KEY0) |=> key[0] == $past(cfg.data))
    else $error("key word 0 not written");

  a_bad_index_ignored: assert property (@(posedge clk) disable iff (rst)
    (cfg_wr && cfg.index != REG_KEY0 && cfg.index != REG_KEY1 &&
     cfg.index != REG_KEY2 && cfg.index != REG_KEY3) |=> $stable(key))
    else $error("key changed by unknown register index");

  a_frozen_pipe: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(pipe_data) && $stable(pipe_valid))
    else $error("pipeline moved while frozen");

endmodule

`default_nettype wire
